[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its antecedent
`define FFCA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// property that must hold in the cycle after its antecedent
`define FFCA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ffca_pkg.sv]
// types, constants and helper functions of the first-fit cell allocator
// used by the controller, the datapath and the top level
package ffca_pkg;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned WORD_LOG  = 6;
  localparam int unsigned IDX_W     = WORD_LOG + 1;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned CELL_W    = 12;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FINIT,
    ST_FILL,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic fill_init;
    logic fill;
    logic rd;
  } ffca_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_free;
    logic free_ok;
    logic alloc_ok;
    logic found;
    logic scan_end;
    logic fill_end;
  } ffca_stat_t;

  // index of the lowest set bit, WORD_BITS when none is set
  function automatic logic [IDX_W-1:0] lowest_one(input logic [WORD_BITS-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = IDX_W'(WORD_BITS);
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (v[k]) begin
        idx = IDX_W'(k);
      end
    end
    return idx;
  endfunction

  // mask with the n lowest bits set
  function automatic logic [WORD_BITS-1:0] low_mask(input logic [IDX_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    if (n >= IDX_W'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (WORD_BITS'(1) << n) - WORD_BITS'(1);
    end
    return m;
  endfunction

endpackage

[rtl/ffca_ctrl.sv]
// controller state machine of the first-fit cell allocator
// depends on ffca_pkg; drives commands to ffca_datapath
module ffca_ctrl import ffca_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  output logic       done_o,
  output ffca_cmd_t  cmd_o,
  input  ffca_stat_t stat_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.op_free) begin
          state_d = stat_i.free_ok ? ST_FINIT : ST_RESP;
        end else begin
          state_d = stat_i.alloc_ok ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        cmd_o.rd   = 1'b1;
        priority if (stat_i.found) begin
          state_d = ST_FINIT;
        end else if (stat_i.scan_end) begin
          state_d = ST_RESP;
        end
      end
      ST_FINIT: begin
        cmd_o.fill_init = 1'b1;
        state_d         = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        cmd_o.rd   = 1'b1;
        if (stat_i.fill_end) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/ffca_datapath.sv]
// datapath of the first-fit cell allocator: used-mark memory, word scanner,
// range fill and result registers; depends on ffca_pkg, driven by ffca_ctrl
module ffca_datapath import ffca_pkg::*; #(
  parameter int unsigned POOL_CELLS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffca_cmd_t         cmd_i,
  output ffca_stat_t        stat_o,
  input  logic              operation_i,
  input  logic [LEN_W-1:0]  run_length_i,
  input  logic [CELL_W-1:0] start_cell_i,
  output logic              granted_o,
  output logic [CELL_W-1:0] granted_cell_o
);

  localparam int unsigned NWORDS    = (POOL_CELLS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned LAST_WORD = NWORDS - 1;
  localparam int unsigned TAIL_BITS = POOL_CELLS - LAST_WORD * WORD_BITS;
  localparam int unsigned PW0       = $clog2(POOL_CELLS + 1);
  localparam int unsigned XW        = ((PW0 > LEN_W) ? PW0 : LEN_W) + 1;
  localparam logic [WORD_BITS-1:0] TAIL_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - TAIL_BITS);
  localparam logic [AW-1:0] LAST_A = AW'(LAST_WORD);
  localparam logic [XW-1:0] POOL_X = XW'(POOL_CELLS);

  logic [WORD_BITS-1:0] mem_q [NWORDS];

  op_e                  op_q;
  logic [LEN_W-1:0]     len_q;
  logic [2:0]           lvl_q;
  logic [WORD_LOG-1:0]  sh_q;
  logic                 small_q;
  logic [XW-1:0]        lo_q, hi_q;
  logic [LEN_W-1:0]     run_q;
  logic [AW-1:0]        raddr_q, pw_q;
  logic                 rd_done_q, pv_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 gr_q;
  logic [CELL_W-1:0]    cell_q;

  // load-time decode
  logic [2:0]          lvl_in;
  logic [WORD_LOG-1:0] sh_in;
  logic                small_in;
  logic [XW-1:0]       sum_in, hi_in;
  logic                op_free_in;

  always_comb begin
    lvl_in = '0;
    for (int k = 0; k <= WORD_LOG; k++) begin
      if (run_length_i[k]) begin
        lvl_in = 3'(k);
      end
    end
    sh_in      = WORD_LOG'(run_length_i[WORD_LOG:0] - (IDX_W'(1) << lvl_in));
    small_in   = run_length_i <= LEN_W'(WORD_BITS);
    sum_in     = XW'(start_cell_i) + XW'(run_length_i);
    hi_in      = (sum_in > POOL_X) ? POOL_X : sum_in;
    op_free_in = operation_i == OP_FREE;
  end

  // word scanner
  logic [WORD_BITS-1:0] free_w, used_rev, win;
  logic [WORD_BITS-1:0] pl [WORD_LOG+1];
  logic [XW-1:0]        base, s_pre, s_int, s_found;
  logic [IDX_W-1:0]     pf, sf, int_i;
  logic [LEN_W:0]       run_ext;
  logic                 pre_hit, int_hit, word_hit, all_free;
  logic [LEN_W-1:0]     run_next;

  always_comb begin
    free_w = ~rdata_q & ((pw_q == LAST_A) ? TAIL_MASK : {WORD_BITS{1'b1}});
    base   = XW'({pw_q, WORD_LOG'(0)});
    for (int k = 0; k < WORD_BITS; k++) begin
      used_rev[k] = ~free_w[WORD_BITS-1-k];
    end
    pf = lowest_one(~free_w);
    sf = lowest_one(used_rev);
    pl[0] = free_w;
    for (int k = 1; k <= WORD_LOG; k++) begin
      pl[k] = pl[k-1] & (pl[k-1] >> (1 << (k - 1)));
    end
    win      = pl[lvl_q] & (pl[lvl_q] >> sh_q);
    int_hit  = small_q && (win != '0);
    int_i    = lowest_one(win);
    run_ext  = (LEN_W+1)'(run_q);
    pre_hit  = (run_ext + (LEN_W+1)'(pf)) >= (LEN_W+1)'(len_q);
    s_pre    = base - XW'(run_q);
    s_int    = base + XW'(int_i);
    s_found  = pre_hit ? s_pre : s_int;
    word_hit = pre_hit || int_hit;
    all_free = &free_w;
    run_next = all_free ? LEN_W'(run_ext + (LEN_W+1)'(WORD_BITS)) : LEN_W'(sf);
  end

  // range fill
  logic [AW-1:0]        lo_w, hi_w, rd_end;
  logic [XW-1:0]        lo_rel, hi_rel;
  logic [IDX_W-1:0]     lo_off, hi_off;
  logic [WORD_BITS-1:0] fill_mask, fill_word, wdata;
  logic [AW-1:0]        waddr;
  logic                 we, rd_en;

  always_comb begin
    lo_w      = AW'(lo_q >> WORD_LOG);
    hi_w      = AW'((hi_q - XW'(1)) >> WORD_LOG);
    lo_rel    = lo_q - base;
    hi_rel    = hi_q - base;
    lo_off    = (lo_q > base) ? IDX_W'(lo_rel) : '0;
    hi_off    = (hi_rel >= XW'(WORD_BITS)) ? IDX_W'(WORD_BITS) : IDX_W'(hi_rel);
    fill_mask = low_mask(hi_off) & ~low_mask(lo_off);
    fill_word = (op_q == OP_ALLOC) ? (rdata_q | fill_mask) : (rdata_q & ~fill_mask);
    we        = cmd_i.clear || (cmd_i.fill && pv_q);
    waddr     = cmd_i.clear ? raddr_q : pw_q;
    wdata     = cmd_i.clear ? '0 : fill_word;
    rd_end    = cmd_i.fill ? hi_w : LAST_A;
    rd_en     = cmd_i.rd && !rd_done_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr_q];
      pw_q    <= raddr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raddr_q   <= '0;
      rd_done_q <= 1'b0;
      pv_q      <= 1'b0;
    end else begin
      pv_q <= rd_en;
      if (cmd_i.load) begin
        raddr_q   <= '0;
        rd_done_q <= 1'b0;
      end else if (cmd_i.fill_init) begin
        raddr_q   <= lo_w;
        rd_done_q <= 1'b0;
      end else if (cmd_i.clear) begin
        raddr_q <= raddr_q + AW'(1);
      end else if (rd_en) begin
        if (raddr_q == rd_end) begin
          rd_done_q <= 1'b1;
        end else begin
          raddr_q <= raddr_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(operation_i);
      len_q   <= run_length_i;
      lvl_q   <= lvl_in;
      sh_q    <= sh_in;
      small_q <= small_in;
      lo_q    <= XW'(start_cell_i);
      hi_q    <= hi_in;
      run_q   <= '0;
      gr_q    <= op_free_in && (XW'(start_cell_i) < POOL_X);
      cell_q  <= op_free_in ? start_cell_i : '0;
    end else if (cmd_i.scan && pv_q) begin
      if (word_hit) begin
        lo_q   <= s_found;
        hi_q   <= s_found + XW'(len_q);
        gr_q   <= 1'b1;
        cell_q <= s_found[CELL_W-1:0];
      end else begin
        run_q <= run_next;
      end
    end
  end

  always_comb begin
    stat_o.clr_last = raddr_q == LAST_A;
    stat_o.op_free  = op_q == OP_FREE;
    stat_o.free_ok  = (lo_q < POOL_X) && (len_q != '0);
    stat_o.alloc_ok = (len_q != '0) && (XW'(len_q) <= POOL_X);
    stat_o.found    = cmd_i.scan && pv_q && word_hit;
    stat_o.scan_end = cmd_i.scan && pv_q && (pw_q == LAST_A);
    stat_o.fill_end = cmd_i.fill && pv_q && (pw_q == hi_w);
  end

  assign granted_o      = gr_q;
  assign granted_cell_o = cell_q;

endmodule

[rtl/first_fit_cell_allocator.sv]
// top level of the first-fit cell allocator
// depends on ffca_pkg, ffca_ctrl and ffca_datapath
//
// The pool holds POOL_CELLS cells, each with a used mark kept in a memory of
// 64-bit words. A request is a transfer on start while busy is low:
// operation_i = 0 allocates run_length_i cells at the lowest fitting free run,
// operation_i = 1 frees run_length_i cells from start_cell_i (clipped at the
// pool end). Every request gives one result, shown for one cycle with done_o
// high on granted_o and granted_cell_o; the receiver has no way to stall it.
// An allocate that finds a run scans the memory words up to and including
// the word where the run is found, then marks the words of the run as used;
// an allocate that fails scans every word of the pool; a free clears the
// marks of its range word by word; a request that changes nothing goes
// straight to the result. The scan reads one memory word a cycle.
// The next request is taken the cycle after done_o.
// After reset the memory is cleared one word a cycle, all ceil(POOL_CELLS/64)
// words (64 at the default), with busy high.
module first_fit_cell_allocator import ffca_pkg::*; #(
  parameter int unsigned POOL_CELLS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              operation_i,
  input  logic [LEN_W-1:0]  run_length_i,
  input  logic [CELL_W-1:0] start_cell_i,
  output logic              done_o,
  output logic              granted_o,
  output logic [CELL_W-1:0] granted_cell_o
);

  ffca_cmd_t  cmd;
  ffca_stat_t stat;

  ffca_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  ffca_datapath #(
    .POOL_CELLS (POOL_CELLS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .operation_i    (operation_i),
    .run_length_i   (run_length_i),
    .start_cell_i   (start_cell_i),
    .granted_o      (granted_o),
    .granted_cell_o (granted_cell_o)
  );

endmodule

[rtl/ffca_checker.sv]
// port-level checker of the first-fit cell allocator and its bind
// depends on assert_macros.svh and first_fit_cell_allocator
`include "assert_macros.svh"

module ffca_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  `FFCA_ASSERT_NOW(a_done_while_busy, done_o, busy, "result strobe while not busy")
  `FFCA_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "busy low after transfer")
  `FFCA_ASSERT_NEXT(a_done_frees, done_o, !busy && !done_o, "not idle after result")

endmodule

bind first_fit_cell_allocator ffca_checker u_ffca_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);
